FILE: rtl/core/b85rac_pkg.sv
package b85rac_pkg;

  // symbols per group and alphabet size
  localparam int unsigned NumLanes = 5;
  localparam logic [6:0] AlphaSize = 7'd85;

  // mode register codes
  localparam logic ModeEnc = 1'b0;
  localparam logic ModeDec = 1'b1;

  // configuration register indexes
  localparam logic CfgMode = 1'b0;
  localparam logic CfgStep = 1'b1;

  // digit weight of each lane, lane 0 is the most significant digit
  localparam logic [25:0] LaneDiv [NumLanes] = '{
    26'd52200625, 26'd614125, 26'd7225, 26'd85, 26'd1
  };

  // floor(2^32 / weight): quotient estimate is low by at most one
  localparam logic [32:0] LaneRecip [NumLanes] = '{
    33'(64'h1_0000_0000 / 64'd52200625),
    33'(64'h1_0000_0000 / 64'd614125),
    33'(64'h1_0000_0000 / 64'd7225),
    33'(64'h1_0000_0000 / 64'd85),
    33'(64'h1_0000_0000 / 64'd1)
  };

  // base alphabet, index 0..84
  localparam logic [7:0] BaseAlpha [85] = '{
    "0", "1", "2", "3", "4", "5", "6", "7", "8", "9",
    "a", "b", "c", "d", "e", "f", "g", "h", "i", "j",
    "k", "l", "m", "n", "o", "p", "q", "r", "s", "t",
    "u", "v", "w", "x", "y", "z", "A", "B", "C", "D",
    "E", "F", "G", "H", "I", "J", "K", "L", "M", "N",
    "O", "P", "Q", "R", "S", "T", "U", "V", "W", "X",
    "Y", "Z", ".", "-", ":", "+", "=", "^", "!", "/",
    "*", "?", "&", "<", ">", "(", ")", "[", "]", "{",
    "}", "@", "%", "$", "#"
  };

  // control shared by the stages of one lane
  typedef struct packed {
    logic en;
    logic mode_a;
    logic mode_c;
  } lane_ctrl_t;

  // result of a reverse alphabet lookup
  typedef struct packed {
    logic       ok;
    logic [6:0] idx;
  } lookup_t;

  // one finished group, vals[0] goes out first
  typedef struct packed {
    logic [4:0][7:0] vals;
    logic [2:0]      cnt;
    logic            bad;
  } group_t;

  // (a + b) mod 85 for a, b below 85
  function automatic logic [6:0] add_mod85(input logic [6:0] a, input logic [6:0] b);
    logic [7:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, AlphaSize}) begin
      s = s - {1'b0, AlphaSize};
    end
    return s[6:0];
  endfunction

  // (k * s) mod 85 for s below 85 and k up to 5
  function automatic logic [6:0] mult_mod85(input logic [6:0] s, input logic [2:0] k);
    logic [9:0] x;
    x = 10'(s) * 10'(k);
    for (int i = 0; i < 4; i++) begin
      if (x >= 10'(AlphaSize)) begin
        x = x - 10'(AlphaSize);
      end
    end
    return x[6:0];
  endfunction

  // character at a base alphabet index
  function automatic logic [7:0] base_char(input logic [6:0] idx);
    logic [7:0] c;
    c = 8'd0;
    if (idx < AlphaSize) begin
      c = BaseAlpha[idx];
    end
    return c;
  endfunction

  // base alphabet index of a character
  function automatic lookup_t char_index(input logic [7:0] c);
    lookup_t r;
    r = '0;
    for (int b = 0; b < 85; b++) begin
      if (c == BaseAlpha[b]) begin
        r.ok  = 1'b1;
        r.idx = 7'(b);
      end
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/base85_rotating_alphabet_codec_unit.sv
// Base-85 codec with an alphabet that rotates right after every symbol. In encode
// mode a word carries up to four bytes (first byte in bits 31..24, byte_count of
// them kept, the rest taken as zero) and gives five characters, most significant
// digit first, with tlast on the fifth. In decode mode a word carries five
// characters and gives byte_count bytes of the rebuilt 32-bit value, with tuser
// set on each of them if any character was not in the alphabet. Each group moves
// the alphabet five steps in both modes. Five lanes work on the five digit
// positions side by side and a merge stage combines them; each input word passes
// the input registers, lane stages a, b and c and the merge registers before the
// output stage takes it. The output port sends one word per cycle while the
// receiver is ready, and a new input word is taken while the previous group is
// still going out. Configuration writes are taken at once.
module base85_rotating_alphabet_codec_unit
  import b85rac_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // data_word[31:0], byte_count[34:32], sym0[42:35], sym1[50:43], sym2[58:51],
  // sym3[66:59], sym4[74:67], zero fill[79:75]
  input  logic [79:0] s_axis_tdata,
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_value[7:0]
  output logic [7:0]  m_axis_tdata,
  output logic        m_axis_tlast,
  // bad_symbol[0]
  output logic [0:0]  m_axis_tuser,
  // register writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_index_i,
  input  logic [6:0]  cfg_data_i
);

  logic            mode_q;
  logic [4:0][6:0] mult_q;
  logic [6:0]      step_mod;
  logic [6:0]      off_q;
  logic            en, acc, srl_ready;
  logic [5:0]      valid_q;

  logic [31:0]     word_in, word_mask;
  logic [2:0]      cnt_raw, cnt_c;
  logic [4:0][6:0] offs_in;

  logic [31:0]     word0_q, word1_q, word2_q;
  logic [2:0]      cnt0_q, cnt1_q, cnt2_q, cnt3_q;
  logic            mode0_q, mode1_q, mode2_q, mode3_q;
  logic [4:0][7:0] syms0_q;
  logic [4:0][6:0] offs0_q, offs1_q, offs2_q, offs3_q;

  lane_ctrl_t       lane_ctrl;
  logic [4:0][31:0] lane_res;
  logic [4:0]       lane_bad;
  group_t           grp;

  // register writes
  assign cfg_ready_o = 1'b1;
  assign step_mod    = (cfg_data_i >= AlphaSize) ? (cfg_data_i - AlphaSize) : cfg_data_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeEnc;
      mult_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgMode: mode_q <= cfg_data_i[0];
        CfgStep: begin
          for (int k = 0; k < NumLanes; k++) begin
            mult_q[k] <= mult_mod85(step_mod, 3'(k + 1));
          end
        end
        default: ;
      endcase
    end
  end

  // pipeline moves as a whole when the tail can hand its group over
  assign en            = !valid_q[5] || srl_ready;
  assign s_axis_tready = en;
  assign acc           = s_axis_tvalid && en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= {valid_q[4:0], acc};
    end
  end

  // running alphabet offset, five steps per group
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q <= 7'd0;
    end else if (acc) begin
      off_q <= add_mod85(off_q, mult_q[4]);
    end
  end

  // unpack, clamp the byte count, zero the unused bytes, lane offsets
  assign word_in = s_axis_tdata[31:0];
  assign cnt_raw = s_axis_tdata[34:32];

  always_comb begin
    case (cnt_raw)
      3'd0, 3'd1: cnt_c = 3'd1;
      3'd2:       cnt_c = 3'd2;
      3'd3:       cnt_c = 3'd3;
      default:    cnt_c = 3'd4;
    endcase
    case (cnt_c)
      3'd1:    word_mask = {word_in[31:24], 24'd0};
      3'd2:    word_mask = {word_in[31:16], 16'd0};
      3'd3:    word_mask = {word_in[31:8], 8'd0};
      default: word_mask = word_in;
    endcase
    offs_in[0] = off_q;
    for (int k = 1; k < NumLanes; k++) begin
      offs_in[k] = add_mod85(off_q, mult_q[k-1]);
    end
  end

  // item fields along the pipeline
  always_ff @(posedge clk_i) begin
    if (en) begin
      word0_q <= word_mask;
      cnt0_q  <= cnt_c;
      mode0_q <= mode_q;
      offs0_q <= offs_in;
      for (int k = 0; k < NumLanes; k++) begin
        syms0_q[k] <= s_axis_tdata[35+8*k +: 8];
      end
      word1_q <= word0_q;
      cnt1_q  <= cnt0_q;
      mode1_q <= mode0_q;
      offs1_q <= offs0_q;
      word2_q <= word1_q;
      cnt2_q  <= cnt1_q;
      mode2_q <= mode1_q;
      offs2_q <= offs1_q;
      cnt3_q  <= cnt2_q;
      mode3_q <= mode2_q;
      offs3_q <= offs2_q;
    end
  end

  // one lane per digit position
  assign lane_ctrl.en     = en;
  assign lane_ctrl.mode_a = mode0_q;
  assign lane_ctrl.mode_c = mode2_q;

  for (genvar k = 0; k < NumLanes; k++) begin : g_lane
    b85rac_lane u_lane (
      .clk_i      (clk_i),
      .ctrl_i     (lane_ctrl),
      .lane_idx_i (3'(k)),
      .word_a_i   (word0_q),
      .sym_a_i    (syms0_q[k]),
      .off_a_i    (offs0_q[k]),
      .word_c_i   (word2_q),
      .res_o      (lane_res[k]),
      .bad_o      (lane_bad[k])
    );
  end

  b85rac_merge u_merge (
    .clk_i  (clk_i),
    .en_i   (en),
    .mode_i (mode3_q),
    .cnt_i  (cnt3_q),
    .offs_i (offs3_q),
    .res_i  (lane_res),
    .bad_i  (lane_bad),
    .grp_o  (grp)
  );

  b85rac_serializer u_serializer (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (valid_q[5]),
    .grp_i    (grp),
    .ready_o  (srl_ready),
    .tvalid_o (m_axis_tvalid),
    .tready_i (m_axis_tready),
    .tdata_o  (m_axis_tdata),
    .tlast_o  (m_axis_tlast),
    .tuser_o  (m_axis_tuser[0])
  );

  // offset stays inside the alphabet
  a_off_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    off_q < AlphaSize)
    else $error("alphabet offset out of range");

  // first and last rotation multiples stay inside the alphabet
  a_mult_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mult_q[0] < AlphaSize) && (mult_q[4] < AlphaSize))
    else $error("rotation multiple out of range");

  // a group handed to the output stage is shown on the next cycle
  a_tail_handoff : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[5] && srl_ready |=> m_axis_tvalid)
    else $error("group lost between pipeline and output stage");

endmodule

FILE: rtl/core/b85rac_lane.sv
module b85rac_lane
  import b85rac_pkg::*;
(
  input  logic       clk_i,
  input  lane_ctrl_t ctrl_i,
  input  logic [2:0] lane_idx_i,
  input  logic [31:0] word_a_i,
  input  logic [7:0] sym_a_i,
  input  logic [6:0] off_a_i,
  input  logic [31:0] word_c_i,
  output logic [31:0] res_o,
  output logic       bad_o
);

  logic [25:0] div;
  logic [32:0] recip;
  logic [64:0] prod_a;
  logic [31:0] qest;
  lookup_t     look;
  logic [6:0]  dig;
  logic [31:0] x_d, x_q;
  logic        bad_d, bad_a_q;
  logic [57:0] prod_b;
  logic [31:0] y_q, x_b_q;
  logic        bad_b_q;
  logic [31:0] rem;
  logic [31:0] res_d, res_q;
  logic        bad_c_q;

  assign div   = LaneDiv[lane_idx_i];
  assign recip = LaneRecip[lane_idx_i];

  // stage a: quotient estimate in encode, symbol to digit in decode
  assign prod_a = {33'd0, word_a_i} * {32'd0, recip};
  assign qest   = prod_a[63:32];
  assign look   = char_index(sym_a_i);

  always_comb begin
    dig = 7'd0;
    if (look.ok) begin
      dig = add_mod85(look.idx, off_a_i);
    end
    x_d   = (ctrl_i.mode_a == ModeEnc) ? qest : {25'd0, dig};
    bad_d = (ctrl_i.mode_a == ModeDec) && !look.ok;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      x_q     <= x_d;
      bad_a_q <= bad_d;
    end
  end

  // stage b: scale by the lane weight, shared by both modes
  assign prod_b = {26'd0, x_q} * {32'd0, div};

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      y_q     <= prod_b[31:0];
      x_b_q   <= x_q;
      bad_b_q <= bad_a_q;
    end
  end

  // stage c: fix the quotient estimate, or pass the weighted digit
  assign rem = word_c_i - y_q;

  always_comb begin
    if (ctrl_i.mode_c == ModeEnc) begin
      res_d = (rem >= {6'd0, div}) ? (x_b_q + 32'd1) : x_b_q;
    end else begin
      res_d = y_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      res_q   <= res_d;
      bad_c_q <= bad_b_q;
    end
  end

  assign res_o = res_q;
  assign bad_o = bad_c_q;

endmodule

FILE: rtl/core/b85rac_merge.sv
module b85rac_merge
  import b85rac_pkg::*;
(
  input  logic             clk_i,
  input  logic             en_i,
  input  logic             mode_i,
  input  logic [2:0]       cnt_i,
  input  logic [4:0][6:0]  offs_i,
  input  logic [4:0][31:0] res_i,
  input  logic [4:0]       bad_i,
  output group_t           grp_o
);

  logic [4:0][31:0] prev;
  logic [4:0][6:0]  idx_d, idx_q;
  logic [31:0]      s01_q, s23_q, t4_q;
  logic             mode_q, bad_q;
  logic [2:0]       cnt_q;
  logic [31:0]      total;
  group_t           grp_d, grp_q;

  // first merge step: digits from adjacent quotients, then undo the rotation
  always_comb begin
    logic [31:0] d32;
    logic [7:0]  diff;
    prev[0] = 32'd0;
    for (int k = 1; k < NumLanes; k++) begin
      prev[k] = res_i[k-1];
    end
    for (int k = 0; k < NumLanes; k++) begin
      d32  = res_i[k] - (prev[k] * 32'd85);
      diff = {1'b0, d32[6:0]} - {1'b0, offs_i[k]};
      if (diff[7]) begin
        diff = diff + {1'b0, AlphaSize};
      end
      idx_d[k] = diff[6:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      idx_q  <= idx_d;
      s01_q  <= res_i[0] + res_i[1];
      s23_q  <= res_i[2] + res_i[3];
      t4_q   <= res_i[4];
      mode_q <= mode_i;
      cnt_q  <= cnt_i;
      bad_q  <= |bad_i;
    end
  end

  // second merge step: characters, or the rebuilt word split into bytes
  assign total = s01_q + s23_q + t4_q;

  always_comb begin
    grp_d = '0;
    if (mode_q == ModeEnc) begin
      for (int k = 0; k < NumLanes; k++) begin
        grp_d.vals[k] = base_char(idx_q[k]);
      end
      grp_d.cnt = 3'(NumLanes);
      grp_d.bad = 1'b0;
    end else begin
      for (int k = 0; k < 4; k++) begin
        grp_d.vals[k] = total[31-8*k -: 8];
      end
      grp_d.cnt = cnt_q;
      grp_d.bad = bad_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      grp_q <= grp_d;
    end
  end

  assign grp_o = grp_q;

endmodule

FILE: rtl/core/b85rac_serializer.sv
module b85rac_serializer
  import b85rac_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  group_t     grp_i,
  output logic       ready_o,
  output logic       tvalid_o,
  input  logic       tready_i,
  output logic [7:0] tdata_o,
  output logic       tlast_o,
  output logic       tuser_o
);

  logic [4:0][7:0] vals_q;
  logic [2:0]      rem_q;
  logic            bad_q, full_q;
  logic            beat, last_beat, take;

  // one word per cycle while the receiver is ready, next group loads as the last word leaves
  assign beat      = full_q && tready_i;
  assign last_beat = beat && (rem_q == 3'd1);
  assign ready_o   = !full_q || last_beat;
  assign take      = valid_i && ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
      rem_q  <= 3'd0;
    end else if (take) begin
      full_q <= 1'b1;
      rem_q  <= grp_i.cnt;
    end else if (beat) begin
      full_q <= !last_beat;
      rem_q  <= rem_q - 3'd1;
    end
  end

  // group payload, shifted down one word per beat
  always_ff @(posedge clk_i) begin
    if (take) begin
      vals_q <= grp_i.vals;
      bad_q  <= grp_i.bad;
    end else if (beat) begin
      vals_q <= {8'd0, vals_q[4:1]};
    end
  end

  assign tvalid_o = full_q;
  assign tdata_o  = vals_q[0];
  assign tlast_o  = (rem_q == 3'd1);
  assign tuser_o  = bad_q;

endmodule

FILE: tb/b85rac_stream_checker.sv
`timescale 1ns / 1ps

module b85rac_stream_checker
  import b85rac_pkg::*;
#(
  parameter logic [8*85-1:0] Glyphs = '0
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // group stream seen at the block input
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [79:0] in_data_i,
  // result stream seen at the block output
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [7:0]  out_data_i,
  input  logic        out_last_i,
  input  logic [0:0]  out_user_i,
  // register writes
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [0:0]  cfg_index_i,
  input  logic [6:0]  cfg_data_i,
  // end of run: anything still owed is a failure
  input  logic        drain_done_i,
  output int unsigned owed_o,
  output int          fail_count_o
);

  localparam int unsigned Radix = 85;
  localparam int MaxPrinted = 40;

  // one result word as the block should send it
  typedef struct packed {
    logic [7:0] value;
    logic       last;
    logic       bad;
  } codec_word_t;

  codec_word_t owed_words[$];
  logic        mode_q;
  logic [6:0]  step_q;
  int unsigned offset_q;
  int          mismatches = 0;
  int unsigned words_seen = 0;
  logic        drained = 1'b0;

  assign fail_count_o = mismatches;

  function automatic logic [7:0] glyph_at(input int unsigned idx);
    return Glyphs[8*(84-idx) +: 8];
  endfunction

  // rotate the alphabet right by the step, step taken mod 85
  function automatic void step_alphabet();
    offset_q = (offset_q + step_q % Radix) % Radix;
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= MaxPrinted) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
  endtask

  // work out the words one accepted group gives and queue them
  task automatic predict_group(input logic [79:0] grp);
    int unsigned cnt;
    int unsigned dig [5];
    int unsigned pos;
    logic [31:0] val;
    logic [7:0]  c;
    logic        bad;
    logic        found;
    codec_word_t item;
    cnt = grp[34:32];
    if (cnt == 0) begin
      cnt = 1;
    end else if (cnt > 4) begin
      cnt = 4;
    end
    if (mode_q == ModeEnc) begin
      // bytes past the count read as zero
      val = grp[31:0];
      if (cnt < 4) begin
        val = val & ~(32'hFFFF_FFFF >> (8 * cnt));
      end
      for (int i = 4; i >= 0; i--) begin
        dig[i] = val % Radix;
        val = val / Radix;
      end
      for (int i = 0; i < 5; i++) begin
        item.value = glyph_at((dig[i] + Radix - offset_q) % Radix);
        item.last  = (i == 4);
        item.bad   = 1'b0;
        owed_words.push_back(item);
        step_alphabet();
      end
    end else begin
      // unknown characters count as digit zero but still rotate
      val = '0;
      bad = 1'b0;
      for (int i = 0; i < 5; i++) begin
        c = grp[35 + 8*i +: 8];
        found = 1'b0;
        pos = 0;
        for (int b = 0; b < Radix; b++) begin
          if (!found && glyph_at(b) == c) begin
            found = 1'b1;
            pos = (b + offset_q) % Radix;
          end
        end
        if (!found) begin
          bad = 1'b1;
        end
        val = val * 32'd85 + pos;
        step_alphabet();
      end
      for (int i = 0; i < cnt; i++) begin
        item.value = val[8*(3-i) +: 8];
        item.last  = (i == cnt - 1);
        item.bad   = bad;
        owed_words.push_back(item);
      end
    end
  endtask

  task automatic check_word(input logic [7:0] value, input logic last, input logic bad);
    codec_word_t exp_w;
    if (owed_words.size() == 0) begin
      report_mismatch($sformatf("word %0d (0x%02h) arrived with nothing owed",
                                words_seen, value));
    end else begin
      exp_w = owed_words.pop_front();
      if (value !== exp_w.value) begin
        report_mismatch($sformatf("word %0d out_value 0x%02h, want 0x%02h",
                                  words_seen, value, exp_w.value));
      end
      if (last !== exp_w.last) begin
        report_mismatch($sformatf("word %0d last %b, want %b", words_seen, last, exp_w.last));
      end
      if (bad !== exp_w.bad) begin
        report_mismatch($sformatf("word %0d bad_symbol %b, want %b",
                                  words_seen, bad, exp_w.bad));
      end
    end
    words_seen++;
  endtask

  // sample all three channels at the edge, results before new groups
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   = ModeEnc;
      step_q   = '0;
      offset_q = 0;
      owed_words.delete();
      owed_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        check_word(out_data_i, out_last_i, out_user_i[0]);
      end
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CfgMode) begin
          mode_q = cfg_data_i[0];
        end else begin
          step_q = cfg_data_i;
        end
      end
      if (in_valid_i && in_ready_i) begin
        predict_group(in_data_i);
      end
      if (drain_done_i && !drained) begin
        drained = 1'b1;
        if (owed_words.size() != 0) begin
          report_mismatch($sformatf("%0d result words never arrived", owed_words.size()));
        end
      end
      owed_o <= owed_words.size();
    end
  end

endmodule

FILE: tb/tb_base85_rotating_alphabet_codec_unit.sv
`timescale 1ns / 1ps

module tb_base85_rotating_alphabet_codec_unit;
  import b85rac_pkg::*;

  localparam logic [8*85-1:0] GlyphStr =
    "0123456789abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ.-:+=^!/*?&<>()[]{}@%$#";
  localparam int unsigned QuietLimit = 4000;
  localparam int unsigned TailCycles = 24;
  localparam int unsigned RandomSegs = 14;
  localparam int unsigned SegWords   = 20;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;
  logic [0:0]  m_axis_tuser;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [0:0]  cfg_index_i = CfgMode;
  logic [6:0]  cfg_data_i = '0;
  logic        drain_done = 1'b0;
  int unsigned owed;
  int          fail_count;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned quiet_cycles = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  base85_rotating_alphabet_codec_unit dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  b85rac_stream_checker #(
    .Glyphs (GlyphStr)
  ) u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_i   (s_axis_tready),
    .in_data_i    (s_axis_tdata),
    .out_valid_i  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_i   (m_axis_tdata),
    .out_last_i   (m_axis_tlast),
    .out_user_i   (m_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .drain_done_i (drain_done),
    .owed_o       (owed),
    .fail_count_o (fail_count)
  );

  // receiver back-pressure
  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  // give up when no channel moves for too long
  always @(posedge clk) begin
    if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [7:0] glyph_at(input int unsigned idx);
    return GlyphStr[8*(84-idx) +: 8];
  endfunction

  // syms[7:0] is the most significant character
  function automatic logic [79:0] pack_group(input logic [31:0] data, input logic [2:0] cnt,
                                             input logic [39:0] syms);
    return {5'b0, syms, cnt, data};
  endfunction

  // 0: none, 1: sender idles, 2: receiver stalls, 3: both
  task automatic set_idle(input int unsigned profile);
    case (profile)
      0: begin
        idle_pct = 0;
        stall_pct = 0;
      end
      1: begin
        idle_pct = 64;
        stall_pct = 0;
      end
      2: begin
        idle_pct = 0;
        stall_pct = 64;
      end
      default: begin
        idle_pct = 30;
        stall_pct = 30;
      end
    endcase
  endtask

  // tvalid stays high into the next word unless a gap is rolled
  task automatic send_word(input logic [79:0] grp);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= grp;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // stop sending and wait until every owed word has come back
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (owed != 0);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [6:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk);
  endtask

  // upper data bits of a mode write are don't-care
  task automatic configure(input logic mode, input logic [6:0] step);
    settle();
    if ($urandom_range(1) == 1) begin
      write_reg(CfgMode, {6'($urandom), mode});
      write_reg(CfgStep, step);
    end else begin
      write_reg(CfgStep, step);
      write_reg(CfgMode, {6'($urandom), mode});
    end
  endtask

  task automatic send_random(input logic mode);
    logic [2:0]  cnt;
    logic [31:0] data;
    logic [39:0] syms;
    cnt  = ($urandom_range(9) == 0) ? 3'($urandom) : 3'($urandom_range(4, 1));
    data = $urandom;
    syms = {$urandom, 8'($urandom)};
    if (mode == ModeDec) begin
      // mostly well-formed groups, some with a stray byte
      for (int i = 0; i < 5; i++) begin
        syms[8*i +: 8] = glyph_at($urandom_range(84));
      end
      if ($urandom_range(3) == 0) begin
        syms[8*$urandom_range(4) +: 8] = 8'($urandom);
      end
    end else begin
      case ($urandom_range(7))
        0: data = '1;
        1: data = '0;
        default: ;
      endcase
    end
    send_word(pack_group(data, cnt, syms));
  endtask

  initial begin
    logic        seg_mode;
    logic [6:0]  seg_step;
    logic [39:0] syms;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    set_idle(0);

    // decode with the alphabet in base order
    configure(ModeDec, 7'd0);
    send_word(pack_group($urandom, 3'd4, {5{"#"}}));
    send_word(pack_group($urandom, 3'd4, {5{"0"}}));
    send_word(pack_group($urandom, 3'd0, {5{"#"}}));
    send_word(pack_group($urandom, 3'd7, {5{"z"}}));
    send_word(pack_group($urandom, 3'd4, {"A", "B", "?", "z", 8'h00}));
    send_word(pack_group($urandom, 3'd2, {8'hFF, "9", 8'h80, "Q", "$"}));
    send_word(pack_group($urandom, 3'd3, {"x", " ", "%", "@", "#"}));

    // encode extremes, padding and out-of-range counts
    configure(ModeEnc, 7'd0);
    send_word(pack_group(32'hFFFF_FFFF, 3'd4, {$urandom, 8'($urandom)}));
    send_word(pack_group(32'h0000_0000, 3'd4, {$urandom, 8'($urandom)}));
    for (int c = 1; c <= 3; c++) begin
      send_word(pack_group(32'hDEAD_BEEF, 3'(c), '0));
    end
    send_word(pack_group(32'hDEAD_BEEF, 3'd0, '1));
    send_word(pack_group(32'hDEAD_BEEF, 3'd5, '0));
    send_word(pack_group(32'hDEAD_BEEF, 3'd7, '1));

    // rotating alphabet, including steps that wrap
    configure(ModeEnc, 7'd84);
    send_word(pack_group(32'h89AB_CDEF, 3'd4, '0));
    send_word(pack_group(32'h89AB_CDEF, 3'd4, '0));
    configure(ModeEnc, 7'd127);
    send_word(pack_group(32'hFFFF_FFFF, 3'd4, '0));
    configure(ModeEnc, 7'd85);
    send_word(pack_group(32'h1234_5678, 3'd4, '0));
    configure(ModeDec, 7'd84);
    for (int n = 0; n < 2; n++) begin
      for (int i = 0; i < 5; i++) begin
        syms[8*i +: 8] = glyph_at($urandom_range(84));
      end
      send_word(pack_group($urandom, (n == 0) ? 3'd4 : 3'd1, syms));
    end

    // random groups over a range of settings and idle profiles
    for (int seg = 0; seg < RandomSegs; seg++) begin
      case (seg)
        0: seg_step = 7'd84;
        1: seg_step = 7'd127;
        2: seg_step = 7'd85;
        3: seg_step = 7'd0;
        default: seg_step = 7'($urandom);
      endcase
      seg_mode = (seg % 2 == 1) ? ModeDec : ModeEnc;
      configure(seg_mode, seg_step);
      set_idle((seg / 2) % 4);
      repeat (SegWords) send_random(seg_mode);
    end

    // drain, then watch for stray words
    settle();
    set_idle(0);
    repeat (TailCycles) @(posedge clk);
    drain_done <= 1'b1;
    repeat (3) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
